// ===== rtl/core/tcce_pkg.sv =====
`timescale 1ns / 1ps

package tcce_pkg;

   // operation codes
   localparam logic [2:0] OP_PUT_CHAR  = 3'd0;
   localparam logic [2:0] OP_WRITE_AT  = 3'd1;
   localparam logic [2:0] OP_CLEAR     = 3'd2;
   localparam logic [2:0] OP_INIT      = 3'd3;
   localparam logic [2:0] OP_READ_CELL = 3'd4;

   // character codes handled by put_char
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_PRINTABLE = 8'h20;

   localparam logic [7:0] TAB_STEP = 8'd4;
   localparam logic [7:0] TAB_MASK = ~8'd3;

   localparam logic [15:0] BLANK_CELL = 16'h0020;

   typedef struct packed {
      logic latch;
      logic exec;
      logic capture;
      logic copy;
      logic fill;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       scroll;
      logic       cnt_last;
      logic       cnt_copy_end;
      logic       rsp_busy;
   } status_type;

endpackage

// ===== rtl/core/tcce_ctrl.sv =====
`timescale 1ns / 1ps

module tcce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tcce_pkg::status_type status,
   output tcce_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_WIPE = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_COPY = 3'd4;
   localparam logic [2:0] S_FILL = 3'd5;
   localparam logic [2:0] S_RESP = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_WIPE: begin
            cmd.fill = 1'b1;
            if (status.cnt_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            unique case (status.op)
               tcce_pkg::OP_PUT_CHAR:  state_in = status.scroll ? S_COPY : S_RESP;
               tcce_pkg::OP_CLEAR:     state_in = S_FILL;
               tcce_pkg::OP_INIT:      state_in = S_FILL;
               tcce_pkg::OP_READ_CELL: state_in = S_READ;
               default:                state_in = S_RESP;
            endcase
         end
         S_READ: begin
            cmd.capture = 1'b1;
            state_in    = S_RESP;
         end
         S_COPY: begin
            cmd.copy = 1'b1;
            if (status.cnt_copy_end) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (status.cnt_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/tcce_datapath.sv =====
`timescale 1ns / 1ps

module tcce_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcce_pkg::cmd_type    cmd,
   output tcce_pkg::status_type status,
   input  logic [2:0]           req_operation,
   input  logic [7:0]           req_char_code,
   input  logic [7:0]           req_attribute,
   input  logic [7:0]           req_column,
   input  logic [7:0]           req_row,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [6:0]           rsp_cursor_column,
   output logic [4:0]           rsp_cursor_row,
   output logic [15:0]          rsp_cell_value
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   // screen store
   logic [15:0] screen_ff [CELLS];
   logic [15:0] rd_data_ff;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0] wr_data;
   logic        rd_en;
   logic [AW-1:0] rd_addr;

   // cursor and sweep counter
   logic [7:0]    col_ff, col_in;
   logic [7:0]    row_ff, row_in;
   logic [AW-1:0] cnt_ff, cnt_in;

   // latched transaction
   logic [2:0]    op_ff;
   logic [7:0]    code_ff;
   logic [7:0]    attr_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic          inside_ff;
   logic [15:0]   cell_ff;

   // response register
   logic          rsp_valid_ff;
   logic [6:0]    rsp_col_ff;
   logic [4:0]    rsp_row_ff;
   logic [15:0]   rsp_cell_ff;

   logic [7:0]  sel_row;
   logic [7:0]  sel_col;
   logic [15:0] row_base;
   logic        cnt_last;
   logic        cnt_copy_end;
   logic        scroll;
   logic [7:0]  row_step;

   assign cnt_last     = (cnt_ff == AW'(CELLS - 1));
   assign cnt_copy_end = (cnt_ff == AW'(CELLS - COLUMNS));

   // cell address of either the cursor (put_char) or the given coordinates
   assign sel_row  = (req_operation == tcce_pkg::OP_PUT_CHAR) ? row_ff : req_row;
   assign sel_col  = (req_operation == tcce_pkg::OP_PUT_CHAR) ? col_ff : req_column;
   assign row_base = 16'(sel_row) * 16'(COLUMNS);
   assign addr_in  = AW'(row_base + 16'(sel_col));

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff     <= req_operation;
         code_ff   <= req_char_code;
         attr_ff   <= req_attribute;
         addr_ff   <= addr_in;
         inside_ff <= (req_column < 8'(COLUMNS)) && (req_row < 8'(ROWS));
      end
      if (cmd.capture) begin
         cell_ff <= inside_ff ? rd_data_ff : 16'h0000;
      end
   end

   // put_char and init cursor movement, scroll request and store port selection
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      row_step = row_ff;
      cnt_in   = cnt_ff;
      scroll   = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff;
      wr_data  = tcce_pkg::BLANK_CELL;
      rd_en    = 1'b0;
      rd_addr  = addr_ff;

      if (cmd.exec) begin
         cnt_in = '0;
         unique case (op_ff)
            tcce_pkg::OP_PUT_CHAR: begin
               unique case (code_ff)
                  tcce_pkg::CHAR_BACKSPACE: begin
                     if (col_ff != 8'd0) begin
                        col_in = col_ff - 8'd1;
                     end else if (row_ff != 8'd0) begin
                        col_in = 8'(COLUMNS - 1);
                        row_in = row_ff - 8'd1;
                     end
                  end
                  tcce_pkg::CHAR_TAB: begin
                     if (col_ff < 8'(COLUMNS - 4)) begin
                        col_in = (col_ff + tcce_pkg::TAB_STEP) & tcce_pkg::TAB_MASK;
                     end
                  end
                  tcce_pkg::CHAR_RETURN: begin
                     col_in = 8'd0;
                  end
                  tcce_pkg::CHAR_NEWLINE: begin
                     col_in   = 8'd0;
                     row_step = row_ff + 8'd1;
                     row_in   = row_step;
                  end
                  default: begin
                     if (code_ff >= tcce_pkg::CHAR_PRINTABLE) begin
                        wr_en   = 1'b1;
                        wr_addr = addr_ff;
                        wr_data = {attr_ff, code_ff};
                        if (col_ff == 8'(COLUMNS - 1)) begin
                           col_in   = 8'd0;
                           row_step = row_ff + 8'd1;
                           row_in   = row_step;
                        end else begin
                           col_in = col_ff + 8'd1;
                        end
                     end
                  end
               endcase
               // past the bottom row: keep the cursor on the last row
               if (row_step == 8'(ROWS)) begin
                  scroll = 1'b1;
                  row_in = 8'(ROWS - 1);
               end
            end
            tcce_pkg::OP_WRITE_AT: begin
               wr_en   = inside_ff;
               wr_addr = addr_ff;
               wr_data = {attr_ff, code_ff};
            end
            tcce_pkg::OP_INIT: begin
               col_in = 8'd0;
               row_in = 8'd0;
            end
            tcce_pkg::OP_READ_CELL: begin
               rd_en = 1'b1;
            end
            default: begin
            end
         endcase
      end else if (cmd.copy) begin
         // read one row ahead, write the previous read one place behind
         wr_en   = (cnt_ff != '0);
         wr_addr = cnt_ff - AW'(1);
         wr_data = rd_data_ff;
         rd_en   = !cnt_copy_end;
         rd_addr = AW'({1'b0, cnt_ff} + (AW + 1)'(COLUMNS));
         if (!cnt_copy_end) begin
            cnt_in = cnt_ff + AW'(1);
         end
      end else if (cmd.fill) begin
         wr_en  = 1'b1;
         cnt_in = cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= screen_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 8'd0;
         row_ff <= 8'd0;
         cnt_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_col_ff  <= col_ff[6:0];
         rsp_row_ff  <= row_ff[4:0];
         rsp_cell_ff <= (op_ff == tcce_pkg::OP_READ_CELL) ? cell_ff : 16'h0000;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cell_value    = rsp_cell_ff;

   assign status.op           = op_ff;
   assign status.scroll       = scroll;
   assign status.cnt_last     = cnt_last;
   assign status.cnt_copy_end = cnt_copy_end;
   assign status.rsp_busy     = rsp_valid_ff && rsp_stall;

endmodule

// ===== rtl/core/text_console_cursor_engine_core.sv =====
`timescale 1ns / 1ps

// character-cell text console: a COLUMNS x ROWS screen store of attribute<<8|char
// cells and a cursor; one response transaction per request transaction, carrying
// the cursor after the operation and, for read_cell, the addressed cell. one
// request is worked on at a time: put_char, write_at and unknown operations go
// from execute straight to response, read_cell adds a registered store read;
// clear and init sweep the store one cell a cycle; a put_char that runs past the
// bottom row adds a scroll (row copy through the single store port pair, then the
// blank last row). after reset the block blanks the store and holds req_stall
// high during that pass. a finished response waits in an output register.

module text_console_cursor_engine_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_attribute,
   input  logic [7:0]  req_column,
   input  logic [7:0]  req_row,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_row,
   output logic [15:0] rsp_cell_value
);

   // command and status between sequencer and datapath
   tcce_pkg::cmd_type    cmd;
   tcce_pkg::status_type status;

   // sequencer: reset blanking pass, execute, cell read, scroll copy, fill, respond
   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // cursor, screen store, sweep counter and response register
   tcce_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_char_code     (req_char_code),
      .req_attribute     (req_attribute),
      .req_column        (req_column),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cell_value    (rsp_cell_value)
   );

endmodule

// ===== rtl/core/tcce_checker.sv =====
`timescale 1ns / 1ps

module tcce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_cell_value
);

   // the blanking pass after reset holds off requests
   a_reset_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken right after reset");

   // an accepted transaction holds req_stall high in the execute state and the state after it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall ##1 req_stall)
      else $error("request taken while previous one in progress");

   // a response only appears while a request is in progress
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request in progress");

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_cell_value))
      else $error("stalled response changed");

endmodule

bind text_console_cursor_engine_core tcce_checker u_tcce_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_cell_value (rsp_cell_value)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = COLUMNS * ROWS;
   localparam int CLK_PERIOD = 12;

   typedef struct {
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
      logic [15:0] cell_value;
   } console_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_operation;
   logic [7:0]  req_char_code;
   logic [7:0]  req_attribute;
   logic [7:0]  req_column;
   logic [7:0]  req_row;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [6:0]  rsp_cursor_column;
   logic [4:0]  rsp_cursor_row;
   logic [15:0] rsp_cell_value;

   // predicted screen contents and cursor
   logic [15:0]     screen_model [0:CELLS-1];
   int              cur_col;
   int              cur_line;
   console_rsp_type expected_rsp_q [$];

   // idling percentages and the long response hold-off
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   bit hold_responses = 1'b0;

   // bookkeeping for the summary
   int error_count   = 0;
   int sent_count    = 0;
   int scroll_count  = 0;
   int read_count    = 0;
   int checked_count = 0;

   text_console_cursor_engine_core #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_char_code     (req_char_code),
      .req_attribute     (req_attribute),
      .req_column        (req_column),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cell_value    (rsp_cell_value)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // generous fixed limit: covers the reset clearing pass, every clear/init
   // sweep and scroll, and all stalls, several times over
   initial begin
      #250_000_000;
      $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor: applies one request to the local screen and cursor and queues
   // the response it must produce
   // ------------------------------------------------------------------------
   task automatic apply_console_op(input logic [2:0] op, input logic [7:0] code,
                                   input logic [7:0] attr, input logic [7:0] col,
                                   input logic [7:0] row);
      console_rsp_type rsp;
      bit              in_range;
      int              idx;
      in_range = (col < COLUMNS) && (row < ROWS);
      idx = int'(row) * COLUMNS + int'(col);
      rsp.cell_value = '0;
      case (op)
         tcce_pkg::OP_PUT_CHAR: begin
            case (code)
               tcce_pkg::CHAR_BACKSPACE: begin
                  // step left, wrap to the end of the previous row, hold at origin
                  if (cur_col > 0) begin
                     cur_col--;
                  end else if (cur_line > 0) begin
                     cur_col = COLUMNS - 1;
                     cur_line--;
                  end
               end
               tcce_pkg::CHAR_TAB: begin
                  // no tab stop left within the last four columns
                  if (cur_col < COLUMNS - 4)
                     cur_col = (cur_col + int'(tcce_pkg::TAB_STEP))
                               & int'({24'hff_ffff, tcce_pkg::TAB_MASK});
               end
               tcce_pkg::CHAR_RETURN: cur_col = 0;
               tcce_pkg::CHAR_NEWLINE: begin
                  cur_col = 0;
                  cur_line++;
               end
               default: begin
                  // printable codes write a cell and advance, other controls drop
                  if (code >= tcce_pkg::CHAR_PRINTABLE) begin
                     screen_model[cur_line * COLUMNS + cur_col] = {attr, code};
                     cur_col++;
                     if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_line++;
                     end
                  end
               end
            endcase
            // past the bottom row: shift everything up one row, blank the last
            if (cur_line >= ROWS) begin
               for (int k = 0; k < CELLS - COLUMNS; k++)
                  screen_model[k] = screen_model[k + COLUMNS];
               for (int k = CELLS - COLUMNS; k < CELLS; k++)
                  screen_model[k] = tcce_pkg::BLANK_CELL;
               cur_line = ROWS - 1;
               scroll_count++;
            end
         end
         tcce_pkg::OP_WRITE_AT: begin
            if (in_range)
               screen_model[idx] = {attr, code};
         end
         tcce_pkg::OP_CLEAR: begin
            for (int k = 0; k < CELLS; k++)
               screen_model[k] = tcce_pkg::BLANK_CELL;
         end
         tcce_pkg::OP_INIT: begin
            for (int k = 0; k < CELLS; k++)
               screen_model[k] = tcce_pkg::BLANK_CELL;
            cur_col  = 0;
            cur_line = 0;
         end
         tcce_pkg::OP_READ_CELL: begin
            read_count++;
            if (in_range)
               rsp.cell_value = screen_model[idx];
         end
         default: ;  // unknown operations change nothing
      endcase
      rsp.cursor_column = 7'(cur_col);
      rsp.cursor_row    = 5'(cur_line);
      expected_rsp_q.push_back(rsp);
   endtask

   // ------------------------------------------------------------------------
   // request driver: called at a falling edge, returns at a falling edge with
   // req_valid still high so a back-to-back transaction never drops it
   // ------------------------------------------------------------------------
   task automatic send_request(input logic [2:0] op, input logic [7:0] code,
                               input logic [7:0] attr, input logic [7:0] col,
                               input logic [7:0] row);
      // random idle cycles before offering the transaction
      while (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_operation = op;
      req_char_code = code;
      req_attribute = attr;
      req_column    = col;
      req_row       = row;
      // payload holds until the block takes it
      do @(posedge clock); while (req_stall);
      apply_console_op(op, code, attr, col, row);
      sent_count++;
      @(negedge clock);
   endtask

   // sender pause: nothing offered until every predicted response has come back
   task automatic wait_for_responses();
      req_valid = 1'b0;
      while (expected_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // response side: stall driven at the falling edge, check at the rising edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_stall = hold_responses || (rsp_idle_pct > 0 && $urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      console_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response transaction with no request outstanding");
            error_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            checked_count++;
            if (rsp_cursor_column !== exp_rsp.cursor_column) begin
               $error("cursor_column: expected %0d, actual %0d",
                      exp_rsp.cursor_column, rsp_cursor_column);
               error_count++;
            end
            if (rsp_cursor_row !== exp_rsp.cursor_row) begin
               $error("cursor_row: expected %0d, actual %0d",
                      exp_rsp.cursor_row, rsp_cursor_row);
               error_count++;
            end
            if (rsp_cell_value !== exp_rsp.cell_value) begin
               $error("cell_value: expected %h, actual %h",
                      exp_rsp.cell_value, rsp_cell_value);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------------

   // store corners after reset, out-of-range reads and writes, extreme bytes
   task automatic test_cell_access();
      send_request(tcce_pkg::OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_READ_CELL, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
      send_request(tcce_pkg::OP_READ_CELL, 8'hff, 8'hff, 8'(COLUMNS), 8'd0);
      send_request(tcce_pkg::OP_READ_CELL, 8'hff, 8'hff, 8'd0, 8'(ROWS));
      send_request(tcce_pkg::OP_READ_CELL, 8'hff, 8'hff, 8'hff, 8'hff);
      send_request(tcce_pkg::OP_WRITE_AT, 8'h00, 8'hff, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_WRITE_AT, 8'hff, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
      // both of these fall off the screen and must leave it alone
      send_request(tcce_pkg::OP_WRITE_AT, 8'h41, 8'h41, 8'(COLUMNS), 8'(ROWS - 1));
      send_request(tcce_pkg::OP_WRITE_AT, 8'h42, 8'h42, 8'(COLUMNS - 1), 8'(ROWS));
      send_request(tcce_pkg::OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_READ_CELL, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1));
   endtask

   // cursor handling of every control code, printable wrap, unknown operations
   task automatic test_control_codes();
      logic [2:0] unknown_op;
      // held at origin
      send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_BACKSPACE, 8'h00, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_PUT_CHAR, 8'h41, 8'h5a, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_TAB, 8'h00, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_NEWLINE, 8'h00, 8'd0, 8'd0);
      // wraps to last column
      send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_BACKSPACE, 8'h00, 8'd0, 8'd0);
      // too close to the edge
      send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_TAB, 8'h00, 8'd0, 8'd0);
      // wraps to next row
      send_request(tcce_pkg::OP_PUT_CHAR, 8'h7e, 8'h81, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_BACKSPACE, 8'h00, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_BACKSPACE, 8'h00, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_RETURN, 8'h00, 8'd0, 8'd0);
      // ignored control
      send_request(tcce_pkg::OP_PUT_CHAR, 8'h01, 8'hff, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_PRINTABLE - 8'd1, 8'hff,
                   8'd0, 8'd0);
      send_request(tcce_pkg::OP_PUT_CHAR, 8'hff, 8'hff, 8'd0, 8'd0);
      unknown_op = tcce_pkg::OP_READ_CELL + 3'd1;
      send_request(unknown_op, 8'hff, 8'hff, 8'd0, 8'd0);
      unknown_op = ~3'd0;
      send_request(unknown_op, 8'h00, 8'h00, 8'd1, 8'd0);
      send_request(tcce_pkg::OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0);
   endtask

   // walk the cursor to the bottom row, scroll once, then clear
   task automatic test_scroll_and_clear();
      send_request(tcce_pkg::OP_INIT, 8'h00, 8'h00, 8'd0, 8'd0);
      repeat (ROWS - 1)
         send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_NEWLINE, 8'h00, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_PUT_CHAR, 8'h78, 8'h1e, 8'd0, 8'd0);
      // scroll
      send_request(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CHAR_NEWLINE, 8'h00, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'(ROWS - 2));
      send_request(tcce_pkg::OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'(ROWS - 1));
      // cursor stays
      send_request(tcce_pkg::OP_CLEAR, 8'h00, 8'h00, 8'd0, 8'd0);
      send_request(tcce_pkg::OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'(ROWS - 2));
   endtask

   // ------------------------------------------------------------------------
   // random traffic: mostly text streams, with cell writes and reads near the
   // cursor, rare sweeps, and some noise
   // ------------------------------------------------------------------------
   task automatic run_random_traffic(input int count);
      logic [2:0] op;
      logic [7:0] code;
      logic [7:0] col;
      logic [7:0] row;
      int         pick;
      int         sub;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         code = 8'($urandom);
         col  = 8'($urandom);
         row  = 8'($urandom);
         if (pick < 62) begin
            op  = tcce_pkg::OP_PUT_CHAR;
            sub = $urandom_range(99);
            if (sub < 8)       code = tcce_pkg::CHAR_NEWLINE;
            else if (sub < 12) code = tcce_pkg::CHAR_TAB;
            else if (sub < 15) code = tcce_pkg::CHAR_BACKSPACE;
            else if (sub < 17) code = tcce_pkg::CHAR_RETURN;
            else if (sub < 19) code = 8'($urandom_range(tcce_pkg::CHAR_PRINTABLE - 1));
            else if (sub < 80) code = 8'($urandom_range(8'h7e, tcce_pkg::CHAR_PRINTABLE));
            // otherwise any byte at all
         end else if (pick < 95) begin
            op = (pick < 76) ? tcce_pkg::OP_WRITE_AT : tcce_pkg::OP_READ_CELL;
            if ($urandom_range(99) < 85) begin
               col = 8'($urandom_range(COLUMNS - 1));
               // favor the cursor row so reads see written text
               row = ($urandom_range(1) == 0) ? 8'(cur_line) : 8'($urandom_range(ROWS - 1));
            end
         end else if (pick < 96) begin
            op = tcce_pkg::OP_CLEAR;
         end else if (pick < 97) begin
            op = tcce_pkg::OP_INIT;
         end else begin
            op = tcce_pkg::OP_READ_CELL + 3'($urandom_range(1, 3));  // unknown codes
         end
         send_request(op, code, 8'($urandom), col, row);
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming, so the
   // block fills up and stalls its request side; then the sender drains
   task automatic test_response_backpressure();
      fork
         begin
            hold_responses = 1'b1;
            repeat (300) @(negedge clock);
            hold_responses = 1'b0;
         end
      join_none
      run_random_traffic(30);
      wait_for_responses();
   endtask

   task automatic test_random_phases();
      req_idle_pct = 7;
      rsp_idle_pct = 45;
      run_random_traffic(330);
      req_idle_pct = 45;
      rsp_idle_pct = 7;
      run_random_traffic(330);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random_traffic(340);
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = tcce_pkg::OP_PUT_CHAR;
      req_char_code = '0;
      req_attribute = '0;
      req_column    = '0;
      req_row       = '0;
      for (int k = 0; k < CELLS; k++)
         screen_model[k] = tcce_pkg::BLANK_CELL;
      cur_col  = 0;
      cur_line = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // the block's clearing pass after reset shows up as req_stall
      test_cell_access();
      test_control_codes();
      test_scroll_and_clear();
      test_response_backpressure();
      test_random_phases();

      wait_for_responses();
      // settle time, then make sure nothing extra appears
      repeat (64) @(negedge clock);

      $display("sent %0d requests, checked %0d responses (%0d cell reads)",
               sent_count, checked_count, read_count);
      $display("text with control codes and %0d scrolls, cell writes, clears, inits, stalls",
               scroll_count);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/tcce_pkg.sv
rtl/core/tcce_ctrl.sv
rtl/core/tcce_datapath.sv
rtl/core/text_console_cursor_engine_core.sv
rtl/core/tcce_checker.sv
sim/testbench.sv
